>>> sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int KEY_W       = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // item operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // register index (paddr[2])
    localparam logic REG_ORDER_SIGNED = 1'b0;

    // control broadcast to every cell
    typedef struct packed {
        logic upd;   // store changes this cycle
        logic ins;   // 1 insert, 0 remove
        logic sgn;   // signed key order
    } t_cell_ctrl;

endpackage
`default_nettype wire

>>> sv/spq_cell.sv
// One slot of the sorted key chain: holds a key, compares it to the new key.
`default_nettype none
module spq_cell
    import spq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire logic             i_occupied,
    input  wire logic [KEY_W-1:0] i_new_key,
    input  wire logic [KEY_W-1:0] i_left_key,
    input  wire logic             i_left_stay,
    input  wire logic [KEY_W-1:0] i_right_key,
    output logic      [KEY_W-1:0] o_key,
    output logic                  o_stay,
    output logic      [KEY_W-1:0] o_next_key
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic [KEY_W-1:0] cmp_a;
    logic [KEY_W-1:0] cmp_b;
    logic             key_lt_new;

    // signed order: flip the sign bits and compare unsigned
    assign cmp_a      = {r_key[KEY_W-1] ^ i_ctrl.sgn, r_key[KEY_W-2:0]};
    assign cmp_b      = {i_new_key[KEY_W-1] ^ i_ctrl.sgn, i_new_key[KEY_W-2:0]};
    assign key_lt_new = cmp_a < cmp_b;

    // keys not below the new key keep their slot
    assign o_stay = i_occupied && !key_lt_new;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.upd) begin
            if (i_ctrl.ins) begin
                if (o_stay) begin
                    n_key = r_key;
                end else if (i_left_stay) begin
                    n_key = i_new_key;
                end else begin
                    n_key = i_left_key;
                end
            end else begin
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key      = r_key;
    assign o_next_key = n_key;

endmodule
`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count, APB register, result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_mode, i_key
//  output   | o_out_valid / i_out_ready  | o_max_key, o_entry_count, o_is_empty, o_rejected
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata, pready (always 1)
//
// Every cell compares and shifts in the same cycle, so one item per cycle is taken unless stalled;
// its result shows in the output register the cycle after the transfer.
// The input is stalled only while a result waits in the output register and
// i_out_ready is low. Reset clears the count, the output valid and order_signed;
// keys in the chain are left as they are and only slots below the count are read.
`default_nettype none
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_mode,
    input  wire logic [KEY_W-1:0]       i_key,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [KEY_W-1:0]       o_max_key,
    output logic      [COUNT_OUT_W-1:0] o_entry_count,
    output logic                        o_is_empty,
    output logic                        o_rejected,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                   r_order_signed;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic [KEY_W-1:0]       r_max_key;
    logic [COUNT_OUT_W-1:0] r_entry_count;
    logic                   r_is_empty;
    logic                   r_rejected;

    logic                   in_xfer;
    logic                   is_full;
    logic                   is_zero;
    logic                   reject;
    logic [CW+COUNT_OUT_W-1:0] count_ext;
    t_cell_ctrl             ctrl;

    logic [KEY_W-1:0] cell_key  [DEPTH];
    logic [KEY_W-1:0] cell_next [DEPTH];
    logic             cell_stay [DEPTH];

    // ---------------- register port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_signed <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_ORDER_SIGNED) begin
            r_order_signed <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ORDER_SIGNED) begin
            prdata[0] = r_order_signed;
        end
    end

    // ---------------- item control ----------------
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign is_full    = r_count == CW'(DEPTH);
    assign is_zero    = r_count == '0;
    assign reject     = (i_mode == MODE_INSERT) ? is_full : is_zero;

    assign ctrl.upd = in_xfer && !reject;
    assign ctrl.ins = i_mode == MODE_INSERT;
    assign ctrl.sgn = r_order_signed;

    always_comb begin
        n_count = r_count;
        if (ctrl.upd) begin
            n_count = ctrl.ins ? r_count + 1'b1 : r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ---------------- cell chain ----------------
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_W-1:0] left_key;
            logic             left_stay;
            logic [KEY_W-1:0] right_key;

            if (g == 0) begin : g_head
                assign left_key  = i_key;
                assign left_stay = 1'b0;
            end else begin : g_body
                assign left_key  = cell_key[g-1];
                assign left_stay = cell_stay[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign right_key = cell_key[g];
            end else begin : g_inner
                assign right_key = cell_key[g+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_occupied  (CW'(g) < r_count),
                .i_new_key   (i_key),
                .i_left_key  (left_key),
                .i_left_stay (left_stay),
                .i_right_key (right_key),
                .o_key       (cell_key[g]),
                .o_stay      (cell_stay[g]),
                .o_next_key  (cell_next[g])
            );
        end
    endgenerate

    // ---------------- result register ----------------
    assign count_ext = {{COUNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_max_key     <= (n_count == '0) ? '0 : cell_next[0];
            r_entry_count <= count_ext[COUNT_OUT_W-1:0];
            r_is_empty    <= n_count == '0;
            r_rejected    <= reject;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_max_key     = r_max_key;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;
    assign o_rejected    = r_rejected;

endmodule
`default_nettype wire

>>> sv/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_ready,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [KEY_W-1:0]       o_max_key,
    input wire logic [COUNT_OUT_W-1:0] o_entry_count,
    input wire logic                   o_is_empty
);

    // a result appears only after an input transfer
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without input transfer");

    // empty flag agrees with count and max reads zero when empty
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0))
                        && (!o_is_empty || o_max_key == '0))
        else $error("empty flag inconsistent");

    // count never exceeds capacity (when it fits the field)
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && DEPTH < 32) |-> (int'(o_entry_count) <= DEPTH))
        else $error("count above capacity");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_max_key)
                                           && $stable(o_entry_count))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_max_key     (o_max_key),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the sorted priority queue: directed and random traffic.
module testbench;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CLK_PERIOD  = 10;
    // no correct run goes this long without a transfer on either channel
    localparam int STALL_LIMIT = 2000;

    localparam logic [APB_ADDR_W-1:0] ADDR_ORDER_SIGNED = {REG_ORDER_SIGNED, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED     = 3'b100;

    typedef struct packed {
        logic [KEY_W-1:0]       max_key;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   is_empty;
        logic                   rejected;
    } t_queue_status;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_ready;
    logic                   i_mode        = MODE_INSERT;
    logic [KEY_W-1:0]       i_key         = '0;
    logic                   o_out_valid;
    logic                   i_out_ready   = 1'b0;
    logic [KEY_W-1:0]       o_max_key;
    logic [COUNT_OUT_W-1:0] o_entry_count;
    logic                   o_is_empty;
    logic                   o_rejected;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // shadow of the store and of the key order
    logic [KEY_W-1:0] shadow_keys[$];
    logic             shadow_signed = 1'b0;
    t_queue_status    pending_status[$];
    t_queue_status    status_due;

    logic idle_on = 1'b1;
    int   n_errors   = 0;
    int   n_sent     = 0;
    int   n_checked  = 0;
    int   n_rejected = 0;
    int   n_full_hit = 0;
    int   n_empty_hit = 0;
    int   stall_cycles = 0;

    sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_max_key    (o_max_key),
        .o_entry_count(o_entry_count),
        .o_is_empty   (o_is_empty),
        .o_rejected   (o_rejected),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    function automatic logic key_below(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        return shadow_signed ? ($signed(a) < $signed(b)) : (a < b);
    endfunction

    // applies one operation to the shadow store and returns the status it must report
    function automatic t_queue_status apply_queue_op(logic mode, logic [KEY_W-1:0] key);
        t_queue_status st;
        int pos;
        st.rejected = 1'b0;
        if (mode == MODE_INSERT) begin
            if (shadow_keys.size() >= QUEUE_DEPTH) begin
                st.rejected = 1'b1;
            end else begin
                // new key goes behind every key that is not smaller
                pos = 0;
                while (pos < shadow_keys.size() && !key_below(shadow_keys[pos], key))
                    pos++;
                shadow_keys.insert(pos, key);
            end
        end else begin
            if (shadow_keys.size() == 0)
                st.rejected = 1'b1;
            else
                void'(shadow_keys.pop_front());
        end
        st.max_key     = (shadow_keys.size() != 0) ? shadow_keys[0] : '0;
        st.entry_count = COUNT_OUT_W'(shadow_keys.size());
        st.is_empty    = (shadow_keys.size() == 0);
        return st;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 7))
            0:       return KEY_W'($urandom_range(0, 7));               // many duplicates
            1:       return 32'h8000_0000 + $urandom_range(0, 7) - 4;    // sign boundary
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 7);
            3:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // sender side: optional gap, then hold the item until it is taken
    task automatic send_item(logic mode, logic [KEY_W-1:0] key);
        if (idle_on && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        do @(posedge i_clk); while (!o_in_ready);
        if (mode == MODE_INSERT && shadow_keys.size() == QUEUE_DEPTH) n_full_hit++;
        if (mode == MODE_REMOVE && shadow_keys.size() == 0) n_empty_hit++;
        pending_status.push_back(apply_queue_op(mode, key));
        n_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ORDER_SIGNED) shadow_signed = data[0];
    endtask

    task automatic drain_store();
        while (shadow_keys.size() != 0) send_item(MODE_REMOVE, $urandom());
    endtask

    // remove from empty, fill to capacity with extremes and duplicates, overflow, drain, underflow
    task automatic test_full_store();
        logic [KEY_W-1:0] fill_keys[QUEUE_DEPTH] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFF,
            32'h0000_0000, 32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE,
            32'h1234_5678, 32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFE};
        send_item(MODE_REMOVE, 32'hFFFF_FFFF);
        foreach (fill_keys[i]) send_item(MODE_INSERT, fill_keys[i]);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        drain_store();
        send_item(MODE_REMOVE, 32'h0000_0000);
        wait_idle();
    endtask

    task automatic test_signed_order();
        apb_write(ADDR_ORDER_SIGNED, 32'h0000_0001);
        send_item(MODE_INSERT, 32'h7FFF_FFFF);
        send_item(MODE_INSERT, 32'h8000_0000);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h8000_0000);
        repeat (6) send_item(MODE_REMOVE, 32'h5555_AAAA);
        wait_idle();
    endtask

    // runs of insert-heavy, balanced and remove-heavy traffic so the count
    // keeps sweeping between empty and full
    task automatic test_random_traffic(int n_items, logic allow_idle);
        int done;
        int run_len;
        int insert_pct;
        idle_on = allow_idle;
        done = 0;
        while (done < n_items) begin
            run_len = $urandom_range(8, 48);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 15;
            endcase
            repeat (run_len) begin
                send_item(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                          random_key());
                done++;
            end
        end
        drain_store();
        wait_idle();
        idle_on = 1'b1;
    endtask

    // a write to an unmapped register must leave the key order alone
    task automatic test_unmapped_register();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        test_random_traffic(230, 1'b1);
    endtask

    // receiver side
    always @(posedge i_clk)
        i_out_ready <= !idle_on || ($urandom_range(0, 99) >= 9);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected result max_key %h count %0d", $time,
                         o_max_key, o_entry_count);
                n_errors++;
            end else begin
                status_due = pending_status.pop_front();
                n_checked++;
                if (status_due.rejected) n_rejected++;
                if (o_max_key !== status_due.max_key) begin
                    $display("%0t: max_key expected %h got %h", $time,
                             status_due.max_key, o_max_key);
                    n_errors++;
                end
                if (o_entry_count !== status_due.entry_count) begin
                    $display("%0t: entry_count expected %0d got %0d", $time,
                             status_due.entry_count, o_entry_count);
                    n_errors++;
                end
                if (o_is_empty !== status_due.is_empty) begin
                    $display("%0t: is_empty expected %b got %b", $time,
                             status_due.is_empty, o_is_empty);
                    n_errors++;
                end
                if (o_rejected !== status_due.rejected) begin
                    $display("%0t: rejected expected %b got %b", $time,
                             status_due.rejected, o_rejected);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                     stall_cycles, pending_status.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_store();
        test_signed_order();

        apb_write(ADDR_ORDER_SIGNED, 32'hFFFF_FFFE);   // only bit 0 counts
        test_random_traffic(230, 1'b1);
        test_unmapped_register();
        apb_write(ADDR_ORDER_SIGNED, 32'h0000_0001);
        test_random_traffic(230, 1'b0);                 // back-to-back, no idling
        apb_write(ADDR_ORDER_SIGNED, 32'h0000_0001);
        test_random_traffic(230, 1'b1);
        apb_write(ADDR_ORDER_SIGNED, 32'h0000_0000);
        test_random_traffic(230, 1'b1);
        apb_write(ADDR_ORDER_SIGNED, 32'h0000_0001);
        test_random_traffic(230, 1'b1);

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("testbench: %0d operations sent, %0d results checked, %0d rejected",
                 n_sent, n_checked, n_rejected);
        $display("testbench: %0d inserts into a full store, %0d removals from empty, %0d errors",
                 n_full_hit, n_empty_hit, n_errors);
        if (n_errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> sorted_priority_queue.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
tb/testbench.sv
